// ----- sv/sgt_pkg.sv -----
// Shared types and codes for the sorted gate table.
package sgt_pkg;

    typedef enum logic [2:0] {
        MODE_INSERT   = 3'd0,
        MODE_REMOVE   = 3'd1,
        MODE_ACTUAL   = 3'd2,
        MODE_WANTED   = 3'd3,
        MODE_STRENGTH = 3'd4,
        MODE_DONE     = 3'd5,
        MODE_PRIORITY = 3'd6,
        MODE_READ     = 3'd7
    } mode_t;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_FULL      = 3'd1,
        STAT_DUPLICATE = 3'd2,
        STAT_NOT_FOUND = 3'd3,
        STAT_BAD_POS   = 3'd4
    } status_t;

    localparam logic [1:0] LIST_ID       = 2'd0;
    localparam logic [1:0] LIST_STRENGTH = 2'd1;
    localparam logic [1:0] LIST_PRIORITY = 2'd2;

    localparam logic REG_STRENGTH_FLOOR = 1'b0;
    localparam logic REG_PRIORITY_FLOOR = 1'b1;

    localparam logic [15:0] STRENGTH_FLOOR_RST = 16'd100;
    localparam logic [7:0]  PRIORITY_FLOOR_RST = 8'd0;

    typedef struct packed {
        logic [15:0] gate_key;
        logic [1:0]  actual_state;
        logic [1:0]  wanted_state;
        logic [15:0] strength;
        logic [7:0]  priority_req;
        logic        todo_flag;
    } gate_rec_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] gate_key;
        logic [1:0]  actual_state;
        logic [1:0]  wanted_state;
        logic [15:0] strength;
        logic [7:0]  priority_req;
        logic        todo_flag;
        logic        done_flag;
        logic [1:0]  list_pick;
        logic [7:0]  position;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [8:0]  entry_count;
        logic [8:0]  strength_count;
        logic [8:0]  priority_count;
        logic [15:0] read_key;
        logic [1:0]  read_actual;
        logic [1:0]  read_wanted;
        logic [15:0] read_strength;
        logic [7:0]  read_priority;
        logic        read_todo;
    } out_word_t;

    typedef struct packed {
        logic clear;
        logic step;
    } rank_ctl_t;

endpackage

// ----- sv/sgt_rank_count.sv -----
// Place counters for one record in both descending rankings.
module sgt_rank_count #(
    parameter int IW = 4
) (
    input  logic              aclk,
    input  sgt_pkg::rank_ctl_t ctl,
    input  logic [15:0]       s_floor,
    input  logic [7:0]        p_floor,
    input  logic [15:0]       ki_s,
    input  logic [7:0]        ki_p,
    input  logic [15:0]       kj_s,
    input  logic [7:0]        kj_p,
    input  logic              j_before_i,
    input  logic              j_is_i,
    output logic [IW-1:0]     s_place,
    output logic [IW-1:0]     p_place,
    output logic              s_qual,
    output logic              p_qual
);

    logic [IW-1:0] s_place_reg, s_place_next;
    logic [IW-1:0] p_place_reg, p_place_next;
    logic          s_ahead, p_ahead;

    assign s_ahead = !j_is_i && (kj_s > s_floor) &&
                     ((kj_s > ki_s) || ((kj_s == ki_s) && j_before_i));
    assign p_ahead = !j_is_i && (kj_p > p_floor) &&
                     ((kj_p > ki_p) || ((kj_p == ki_p) && j_before_i));

    always_comb begin
        s_place_next = s_place_reg;
        p_place_next = p_place_reg;
        if (ctl.clear) begin
            s_place_next = '0;
            p_place_next = '0;
        end else if (ctl.step) begin
            s_place_next = s_place_reg + IW'(s_ahead);
            p_place_next = p_place_reg + IW'(p_ahead);
        end
    end

    always_ff @(posedge aclk) begin
        s_place_reg <= s_place_next;
        p_place_reg <= p_place_next;
    end

    assign s_place = s_place_reg;
    assign p_place = p_place_reg;
    assign s_qual  = ki_s > s_floor;
    assign p_qual  = ki_p > p_floor;

endmodule

// ----- sv/sorted_gate_table_with_rankings.sv -----
// Sorted gate table with strength and priority rankings, top level.
//
//  channel | ports                          | direction
//  --------+--------------------------------+----------
//  input   | s_valid s_ready s_data         | in
//  result  | m_valid m_ready m_data         | out
//  config  | cfg_wr_en cfg_index cfg_wr_data| in
//
// One word at a time. Search reads every stored record in turn, an insert or
// remove shifts records one by one, and a rebuild ranks each record against
// every record, all paced by the single read port of the record memory.
// Reset is synchronous and empties the table.
// A stalled result holds in the output register; the next word waits.
module sorted_gate_table_with_rankings #(
    parameter int GATE_SLOTS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  sgt_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output sgt_pkg::out_word_t m_data,
    input  logic               cfg_wr_en,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_wr_data
);

    localparam int IW = (GATE_SLOTS > 1) ? $clog2(GATE_SLOTS) : 1;
    localparam int CW = $clog2(GATE_SLOTS + 1);
    localparam int RW = IW + 1;

    typedef enum logic [18:0] {
        S_IDLE     = 19'b000_0000_0000_0000_0001,
        S_FIND_RD  = 19'b000_0000_0000_0000_0010,
        S_FIND_CHK = 19'b000_0000_0000_0000_0100,
        S_INS_RD   = 19'b000_0000_0000_0000_1000,
        S_INS_WR   = 19'b000_0000_0000_0001_0000,
        S_PUT      = 19'b000_0000_0000_0010_0000,
        S_RM_RD    = 19'b000_0000_0000_0100_0000,
        S_RM_WR    = 19'b000_0000_0000_1000_0000,
        S_UPD      = 19'b000_0000_0001_0000_0000,
        S_RK_I     = 19'b000_0000_0010_0000_0000,
        S_RK_ILAT  = 19'b000_0000_0100_0000_0000,
        S_RK_J     = 19'b000_0000_1000_0000_0000,
        S_RK_JCHK  = 19'b000_0001_0000_0000_0000,
        S_RK_WS    = 19'b000_0010_0000_0000_0000,
        S_RK_WP    = 19'b000_0100_0000_0000_0000,
        S_RD_RANK  = 19'b000_1000_0000_0000_0000,
        S_RD_REC   = 19'b001_0000_0000_0000_0000,
        S_WAIT     = 19'b010_0000_0000_0000_0000,
        S_DONE     = 19'b100_0000_0000_0000_0000
    } state_t;

    state_t              state_reg, state_next;
    sgt_pkg::in_word_t   op_reg, op_next;
    logic [CW-1:0]       total_reg, total_next;
    logic [CW-1:0]       stot_reg, stot_next;
    logic [CW-1:0]       ptot_reg, ptot_next;
    logic [CW-1:0]       sn_reg, sn_next;
    logic [CW-1:0]       pn_reg, pn_next;
    logic [CW-1:0]       ptr_reg, ptr_next;
    logic [CW-1:0]       jdx_reg, jdx_next;
    logic [CW-1:0]       at_reg, at_next;
    logic                hit_reg, hit_next;
    logic [IW-1:0]       hit_idx_reg, hit_idx_next;
    logic [15:0]         s_floor_reg;
    logic [7:0]          p_floor_reg;
    logic [15:0]         ki_s_reg, ki_s_next;
    logic [7:0]          ki_p_reg, ki_p_next;
    sgt_pkg::status_t    status_reg, status_next;
    logic                rd_ok_reg, rd_ok_next;
    sgt_pkg::gate_rec_t  rd_rec_reg, rd_rec_next;
    logic                m_valid_reg, m_valid_next;
    sgt_pkg::out_word_t  m_data_reg, m_data_next;

    sgt_pkg::gate_rec_t  rec_mem [GATE_SLOTS];
    sgt_pkg::gate_rec_t  rec_q, rec_wdata;
    logic [IW-1:0]       rec_raddr, rec_waddr;
    logic                rec_we;
    logic [IW-1:0]       rank_mem [2*GATE_SLOTS];
    logic [IW-1:0]       rank_q, rank_wdata;
    logic [RW-1:0]       rank_raddr, rank_waddr;
    logic                rank_we;

    sgt_pkg::rank_ctl_t  rk_ctl;
    logic [IW-1:0]       s_place, p_place;
    logic                s_qual, p_qual;
    sgt_pkg::gate_rec_t  new_rec, upd_rec;
    logic [8:0]          pos_ext;

    always_ff @(posedge aclk) begin
        if (rec_we) begin
            rec_mem[rec_waddr] <= rec_wdata;
        end
        rec_q <= rec_mem[rec_raddr];
    end

    always_ff @(posedge aclk) begin
        if (rank_we) begin
            rank_mem[rank_waddr] <= rank_wdata;
        end
        rank_q <= rank_mem[rank_raddr];
    end

    sgt_rank_count #(.IW(IW)) u_rank_count (
        .aclk       (aclk),
        .ctl        (rk_ctl),
        .s_floor    (s_floor_reg),
        .p_floor    (p_floor_reg),
        .ki_s       (ki_s_reg),
        .ki_p       (ki_p_reg),
        .kj_s       (rec_q.strength),
        .kj_p       (rec_q.priority_req),
        .j_before_i (jdx_reg < ptr_reg),
        .j_is_i     (jdx_reg == ptr_reg),
        .s_place    (s_place),
        .p_place    (p_place),
        .s_qual     (s_qual),
        .p_qual     (p_qual)
    );

    assign pos_ext = {1'b0, op_reg.position};

    always_comb begin
        new_rec.gate_key     = op_reg.gate_key;
        new_rec.actual_state = op_reg.actual_state;
        new_rec.wanted_state = op_reg.wanted_state;
        new_rec.strength     = op_reg.strength;
        new_rec.priority_req = op_reg.priority_req;
        new_rec.todo_flag    = op_reg.todo_flag;
        upd_rec = rec_q;
        case (op_reg.mode)
            sgt_pkg::MODE_ACTUAL:   upd_rec.actual_state = op_reg.actual_state;
            sgt_pkg::MODE_WANTED:   upd_rec.wanted_state = op_reg.wanted_state;
            sgt_pkg::MODE_STRENGTH: upd_rec.strength     = op_reg.strength;
            sgt_pkg::MODE_DONE:     upd_rec.todo_flag    = !op_reg.done_flag;
            sgt_pkg::MODE_PRIORITY: upd_rec.priority_req = op_reg.priority_req;
            default:                upd_rec = rec_q;
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        total_next   = total_reg;
        stot_next    = stot_reg;
        ptot_next    = ptot_reg;
        sn_next      = sn_reg;
        pn_next      = pn_reg;
        ptr_next     = ptr_reg;
        jdx_next     = jdx_reg;
        at_next      = at_reg;
        hit_next     = hit_reg;
        hit_idx_next = hit_idx_reg;
        ki_s_next    = ki_s_reg;
        ki_p_next    = ki_p_reg;
        status_next  = status_reg;
        rd_ok_next   = rd_ok_reg;
        rd_rec_next  = rd_rec_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        rec_raddr    = ptr_reg[IW-1:0];
        rec_we       = 1'b0;
        rec_waddr    = ptr_reg[IW-1:0];
        rec_wdata    = rec_q;
        rank_raddr   = {op_reg.list_pick == sgt_pkg::LIST_PRIORITY, op_reg.position[IW-1:0]};
        rank_we      = 1'b0;
        rank_waddr   = {1'b0, s_place};
        rank_wdata   = ptr_reg[IW-1:0];
        rk_ctl       = '0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next     = s_data;
                    status_next = sgt_pkg::STAT_OK;
                    rd_ok_next  = 1'b0;
                    ptr_next    = '0;
                    at_next     = '0;
                    hit_next    = 1'b0;
                    state_next  = S_FIND_RD;
                    if (s_data.mode == sgt_pkg::MODE_INSERT &&
                        total_reg == CW'(GATE_SLOTS)) begin
                        status_next = sgt_pkg::STAT_FULL;
                        state_next  = S_DONE;
                    end else if (s_data.mode == sgt_pkg::MODE_READ) begin
                        state_next = S_RD_RANK;
                    end
                end
            end
            S_FIND_RD: begin
                if (ptr_reg == total_reg) begin
                    if (op_reg.mode == sgt_pkg::MODE_INSERT) begin
                        if (hit_reg) begin
                            status_next = sgt_pkg::STAT_DUPLICATE;
                            state_next  = S_DONE;
                        end else begin
                            state_next = S_INS_RD;
                        end
                    end else if (!hit_reg) begin
                        status_next = sgt_pkg::STAT_NOT_FOUND;
                        state_next  = S_DONE;
                    end else if (op_reg.mode == sgt_pkg::MODE_REMOVE) begin
                        ptr_next   = CW'(hit_idx_reg);
                        state_next = S_RM_RD;
                    end else begin
                        ptr_next   = CW'(hit_idx_reg);
                        rec_raddr  = hit_idx_reg;
                        state_next = S_UPD;
                    end
                end else begin
                    state_next = S_FIND_CHK;
                end
            end
            S_FIND_CHK: begin
                if (rec_q.gate_key == op_reg.gate_key) begin
                    hit_next     = 1'b1;
                    hit_idx_next = ptr_reg[IW-1:0];
                end
                if (rec_q.gate_key < op_reg.gate_key) begin
                    at_next = at_reg + 1'b1;
                end
                ptr_next   = ptr_reg + 1'b1;
                rec_raddr  = ptr_next[IW-1:0];
                state_next = S_FIND_RD;
            end
            S_INS_RD: begin
                rec_raddr = ptr_reg[IW-1:0] - 1'b1;
                if (ptr_reg == at_reg) begin
                    state_next = S_PUT;
                end else begin
                    state_next = S_INS_WR;
                end
            end
            S_INS_WR: begin
                rec_we     = 1'b1;
                ptr_next   = ptr_reg - 1'b1;
                state_next = S_INS_RD;
            end
            S_PUT: begin
                rec_we     = 1'b1;
                rec_wdata  = new_rec;
                total_next = total_reg + 1'b1;
                ptr_next   = '0;
                sn_next    = '0;
                pn_next    = '0;
                state_next = S_RK_I;
            end
            S_RM_RD: begin
                rec_raddr = ptr_reg[IW-1:0] + 1'b1;
                if (ptr_reg + 1'b1 >= total_reg) begin
                    total_next = total_reg - 1'b1;
                    ptr_next   = '0;
                    sn_next    = '0;
                    pn_next    = '0;
                    state_next = S_RK_I;
                end else begin
                    state_next = S_RM_WR;
                end
            end
            S_RM_WR: begin
                rec_we     = 1'b1;
                ptr_next   = ptr_reg + 1'b1;
                state_next = S_RM_RD;
            end
            S_UPD: begin
                // rec_q holds the hit record here: read issued in S_FIND_RD
                rec_we    = 1'b1;
                rec_wdata = upd_rec;
                if (op_reg.mode == sgt_pkg::MODE_STRENGTH ||
                    op_reg.mode == sgt_pkg::MODE_PRIORITY) begin
                    ptr_next   = '0;
                    sn_next    = '0;
                    pn_next    = '0;
                    state_next = S_RK_I;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_RK_I: begin
                if (ptr_reg == total_reg) begin
                    stot_next  = sn_reg;
                    ptot_next  = pn_reg;
                    state_next = S_DONE;
                end else begin
                    state_next = S_RK_ILAT;
                end
            end
            S_RK_ILAT: begin
                ki_s_next  = rec_q.strength;
                ki_p_next  = rec_q.priority_req;
                jdx_next   = '0;
                rk_ctl.clear = 1'b1;
                state_next = S_RK_J;
            end
            S_RK_J: begin
                rec_raddr = jdx_reg[IW-1:0];
                if (jdx_reg == total_reg) begin
                    state_next = S_RK_WS;
                end else begin
                    state_next = S_RK_JCHK;
                end
            end
            S_RK_JCHK: begin
                rk_ctl.step = 1'b1;
                jdx_next    = jdx_reg + 1'b1;
                state_next  = S_RK_J;
            end
            S_RK_WS: begin
                if (s_qual) begin
                    rank_we    = 1'b1;
                    rank_waddr = {1'b0, s_place};
                    sn_next    = sn_reg + 1'b1;
                end
                state_next = S_RK_WP;
            end
            S_RK_WP: begin
                if (p_qual) begin
                    rank_we    = 1'b1;
                    rank_waddr = {1'b1, p_place};
                    pn_next    = pn_reg + 1'b1;
                end
                ptr_next   = ptr_reg + 1'b1;
                state_next = S_RK_I;
            end
            S_RD_RANK: begin
                rec_raddr = op_reg.position[IW-1:0];
                if (op_reg.list_pick == sgt_pkg::LIST_ID && pos_ext < 9'(total_reg)) begin
                    state_next = S_WAIT;
                end else if ((op_reg.list_pick == sgt_pkg::LIST_STRENGTH &&
                              pos_ext < 9'(stot_reg)) ||
                             (op_reg.list_pick == sgt_pkg::LIST_PRIORITY &&
                              pos_ext < 9'(ptot_reg))) begin
                    state_next = S_RD_REC;
                end else begin
                    status_next = sgt_pkg::STAT_BAD_POS;
                    state_next  = S_DONE;
                end
            end
            S_RD_REC: begin
                rec_raddr  = rank_q;
                state_next = S_WAIT;
            end
            S_WAIT: begin
                rd_ok_next  = 1'b1;
                rd_rec_next = rec_q;
                state_next  = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next               = 1'b1;
                    m_data_next.status         = status_reg;
                    m_data_next.entry_count    = 9'(total_reg);
                    m_data_next.strength_count = 9'(stot_reg);
                    m_data_next.priority_count = 9'(ptot_reg);
                    m_data_next.read_key       = rd_ok_reg ? rd_rec_reg.gate_key : '0;
                    m_data_next.read_actual    = rd_ok_reg ? rd_rec_reg.actual_state : '0;
                    m_data_next.read_wanted    = rd_ok_reg ? rd_rec_reg.wanted_state : '0;
                    m_data_next.read_strength  = rd_ok_reg ? rd_rec_reg.strength : '0;
                    m_data_next.read_priority  = rd_ok_reg ? rd_rec_reg.priority_req : '0;
                    m_data_next.read_todo      = rd_ok_reg ? rd_rec_reg.todo_flag : 1'b0;
                    state_next                 = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            total_reg   <= '0;
            stot_reg    <= '0;
            ptot_reg    <= '0;
            m_valid_reg <= 1'b0;
            s_floor_reg <= sgt_pkg::STRENGTH_FLOOR_RST;
            p_floor_reg <= sgt_pkg::PRIORITY_FLOOR_RST;
        end else begin
            state_reg   <= state_next;
            total_reg   <= total_next;
            stot_reg    <= stot_next;
            ptot_reg    <= ptot_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en && cfg_index == sgt_pkg::REG_STRENGTH_FLOOR) begin
                s_floor_reg <= cfg_wr_data;
            end
            if (cfg_wr_en && cfg_index == sgt_pkg::REG_PRIORITY_FLOOR) begin
                p_floor_reg <= cfg_wr_data[7:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        sn_reg      <= sn_next;
        pn_reg      <= pn_next;
        ptr_reg     <= ptr_next;
        jdx_reg     <= jdx_next;
        at_reg      <= at_next;
        hit_reg     <= hit_next;
        hit_idx_reg <= hit_idx_next;
        ki_s_reg    <= ki_s_next;
        ki_p_reg    <= ki_p_next;
        status_reg  <= status_next;
        rd_ok_reg   <= rd_ok_next;
        rd_rec_reg  <= rd_rec_next;
        m_data_reg  <= m_data_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_onehot_state: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("state register not one-hot");

    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= CW'(GATE_SLOTS))
        else $error("record total above capacity");

    a_rank_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> (stot_reg <= total_reg && ptot_reg <= total_reg))
        else $error("ranking larger than table");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("accepted a word without leaving idle");

endmodule

// ----- test/sorted_gate_table_with_rankings_tb.sv -----
// Testbench for the sorted gate table: random and directed words checked against a predictor.
`timescale 1ns / 100ps

class gate_table_scoreboard;
    sgt_pkg::gate_rec_t  recs[16];
    int                  rec_n;
    int                  str_n;
    int                  pri_n;
    int                  str_rank[16];
    int                  pri_rank[16];
    logic [15:0]         str_floor;
    logic [7:0]          pri_floor;
    sgt_pkg::out_word_t  want_q[$];
    int                  errors;
    int                  checked;

    function new();
        rec_n     = 0;
        str_n     = 0;
        pri_n     = 0;
        str_floor = sgt_pkg::STRENGTH_FLOOR_RST;
        pri_floor = sgt_pkg::PRIORITY_FLOOR_RST;
        errors    = 0;
        checked   = 0;
    endfunction

    function int key_at(int i, bit by_str);
        return by_str ? int'(recs[i].strength) : int'(recs[i].priority_req);
    endfunction

    function int rank_into(bit by_str);
        int n;
        int place;
        int ki;
        int kj;
        int flr;
        n = 0;
        flr = by_str ? int'(str_floor) : int'(pri_floor);
        for (int i = 0; i < rec_n; i++) begin
            ki = key_at(i, by_str);
            if (ki <= flr) continue;
            place = 0;
            for (int j = 0; j < rec_n; j++) begin
                kj = key_at(j, by_str);
                if (kj <= flr || j == i) continue;
                if (kj > ki || (kj == ki && j < i)) place++;
            end
            if (by_str) str_rank[place] = i;
            else pri_rank[place] = i;
            n++;
        end
        return n;
    endfunction

    function void rerank();
        str_n = rank_into(1'b1);
        pri_n = rank_into(1'b0);
    endfunction

    function int find_gate(logic [15:0] k);
        for (int i = 0; i < rec_n; i++)
            if (recs[i].gate_key == k) return i;
        return -1;
    endfunction

    function sgt_pkg::out_word_t predict(sgt_pkg::in_word_t w);
        sgt_pkg::out_word_t o;
        int                 at;
        int                 f;
        int                 idx;
        bit                 ok;
        o = '0;
        o.status = sgt_pkg::STAT_OK;
        if (sgt_pkg::mode_t'(w.mode) == sgt_pkg::MODE_INSERT) begin
            if (rec_n >= 16) begin
                o.status = sgt_pkg::STAT_FULL;
            end else if (find_gate(w.gate_key) >= 0) begin
                o.status = sgt_pkg::STAT_DUPLICATE;
            end else begin
                at = 0;
                while (at < rec_n && recs[at].gate_key < w.gate_key) at++;
                for (int i = rec_n; i > at; i--) recs[i] = recs[i-1];
                recs[at] = '{w.gate_key, w.actual_state, w.wanted_state,
                             w.strength, w.priority_req, w.todo_flag};
                rec_n++;
                rerank();
            end
        end else if (sgt_pkg::mode_t'(w.mode) == sgt_pkg::MODE_READ) begin
            ok = 1'b0;
            idx = 0;
            if (w.list_pick == sgt_pkg::LIST_ID && w.position < rec_n) begin
                idx = w.position;
                ok = 1'b1;
            end else if (w.list_pick == sgt_pkg::LIST_STRENGTH && w.position < str_n) begin
                idx = str_rank[w.position];
                ok = 1'b1;
            end else if (w.list_pick == sgt_pkg::LIST_PRIORITY && w.position < pri_n) begin
                idx = pri_rank[w.position];
                ok = 1'b1;
            end
            if (ok) begin
                o.read_key      = recs[idx].gate_key;
                o.read_actual   = recs[idx].actual_state;
                o.read_wanted   = recs[idx].wanted_state;
                o.read_strength = recs[idx].strength;
                o.read_priority = recs[idx].priority_req;
                o.read_todo     = recs[idx].todo_flag;
            end else begin
                o.status = sgt_pkg::STAT_BAD_POS;
            end
        end else begin
            f = find_gate(w.gate_key);
            if (f < 0) begin
                o.status = sgt_pkg::STAT_NOT_FOUND;
            end else begin
                case (sgt_pkg::mode_t'(w.mode))
                    sgt_pkg::MODE_REMOVE: begin
                        for (int i = f; i + 1 < rec_n; i++) recs[i] = recs[i+1];
                        rec_n--;
                        rerank();
                    end
                    sgt_pkg::MODE_ACTUAL: recs[f].actual_state = w.actual_state;
                    sgt_pkg::MODE_WANTED: recs[f].wanted_state = w.wanted_state;
                    sgt_pkg::MODE_STRENGTH: begin
                        recs[f].strength = w.strength;
                        rerank();
                    end
                    sgt_pkg::MODE_DONE: recs[f].todo_flag = ~w.done_flag;
                    default: begin
                        recs[f].priority_req = w.priority_req;
                        rerank();
                    end
                endcase
            end
        end
        o.entry_count    = 9'(rec_n);
        o.strength_count = 9'(str_n);
        o.priority_count = 9'(pri_n);
        return o;
    endfunction

    function void note_word(sgt_pkg::in_word_t w);
        want_q.push_back(predict(w));
    endfunction

    task report(string what, longint got, longint exp);
        $display("mismatch on result %0d: %s got %0d expected %0d", checked, what, got, exp);
        errors++;
    endtask

    task check_word(sgt_pkg::out_word_t got);
        sgt_pkg::out_word_t exp;
        if (want_q.size() == 0) begin
            report("unexpected word", 1, 0);
            return;
        end
        exp = want_q.pop_front();
        if (got.status !== exp.status) report("status", got.status, exp.status);
        if (got.entry_count !== exp.entry_count)
            report("entry_count", got.entry_count, exp.entry_count);
        if (got.strength_count !== exp.strength_count)
            report("strength_count", got.strength_count, exp.strength_count);
        if (got.priority_count !== exp.priority_count)
            report("priority_count", got.priority_count, exp.priority_count);
        if (got.read_key !== exp.read_key) report("read_key", got.read_key, exp.read_key);
        if (got.read_actual !== exp.read_actual)
            report("read_actual", got.read_actual, exp.read_actual);
        if (got.read_wanted !== exp.read_wanted)
            report("read_wanted", got.read_wanted, exp.read_wanted);
        if (got.read_strength !== exp.read_strength)
            report("read_strength", got.read_strength, exp.read_strength);
        if (got.read_priority !== exp.read_priority)
            report("read_priority", got.read_priority, exp.read_priority);
        if (got.read_todo !== exp.read_todo) report("read_todo", got.read_todo, exp.read_todo);
        checked++;
    endtask
endclass

module sorted_gate_table_with_rankings_tb;
    localparam longint CYCLE_LIMIT = 6000000;
    localparam int     PHASE_WORDS = 310;
    localparam int     HOLD_CYCLES = 3000;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    sgt_pkg::in_word_t   s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    sgt_pkg::out_word_t  m_data;
    logic                cfg_wr_en = 1'b0;
    logic                cfg_index = sgt_pkg::REG_STRENGTH_FLOOR;
    logic [15:0]         cfg_wr_data = '0;

    gate_table_scoreboard sb = new();
    longint cycles = 0;
    bit     no_idle = 1'b0;
    bit     hold_req = 1'b0;
    int     hold_left = 0;
    int     sent = 0;

    sorted_gate_table_with_rankings dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_word(m_data);
    end

    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            m_ready <= no_idle || ($urandom_range(0, 99) >= 36);
        end
    end

    task send_word(sgt_pkg::in_word_t w);
        if (!no_idle && $urandom_range(0, 99) < 36) begin
            s_valid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(0, 99) < 36);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        sb.note_word(w);
        sent++;
        @(negedge aclk);
    endtask

    task write_reg(logic idx, logic [15:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == sgt_pkg::REG_STRENGTH_FLOOR) sb.str_floor = val;
        else sb.pri_floor = val[7:0];
        @(negedge aclk);
    endtask

    task drain();
        s_valid <= 1'b0;
        while (sb.want_q.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    function sgt_pkg::in_word_t op(sgt_pkg::mode_t m, logic [15:0] k, logic [15:0] str,
                                   logic [7:0] pri, logic [1:0] pick, logic [7:0] pos);
        sgt_pkg::in_word_t w;
        w = '0;
        w.mode = m;
        w.gate_key = k;
        w.strength = str;
        w.priority_req = pri;
        w.list_pick = pick;
        w.position = pos;
        return w;
    endfunction

    function logic [15:0] pick_strength();
        case ($urandom_range(0, 5))
            0: return sb.str_floor;
            1: return sb.str_floor + 16'd1;
            2: return 16'd65535;
            3: return 16'd0;
            4: return 16'($urandom_range(95, 110));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function logic [7:0] pick_priority();
        case ($urandom_range(0, 4))
            0: return sb.pri_floor;
            1: return sb.pri_floor + 8'd1;
            2: return 8'($urandom_range(0, 3) * 85);
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function sgt_pkg::in_word_t make_word();
        sgt_pkg::in_word_t w;
        int                r;
        w = '0;
        r = $urandom_range(0, 99);
        if (r < (sb.rec_n < 10 ? 45 : 22)) w.mode = sgt_pkg::MODE_INSERT;
        else if (r < 60) w.mode = sgt_pkg::MODE_READ;
        else w.mode = 3'($urandom_range(1, 6));
        if (sb.rec_n > 0 && $urandom_range(0, 99) < 55)
            w.gate_key = sb.recs[$urandom_range(0, sb.rec_n - 1)].gate_key;
        else if ($urandom_range(0, 99) < 70)
            w.gate_key = 16'($urandom_range(0, 31));
        else
            w.gate_key = 16'($urandom_range(0, 65535));
        w.actual_state = 2'($urandom_range(0, 3));
        w.wanted_state = 2'($urandom_range(0, 3));
        w.strength     = pick_strength();
        w.priority_req = pick_priority();
        w.todo_flag    = 1'($urandom_range(0, 1));
        w.done_flag    = 1'($urandom_range(0, 1));
        w.list_pick    = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
        w.position     = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 17))
                                                    : 8'($urandom_range(0, 255));
        return w;
    endfunction

    initial begin
        logic [15:0]        sfl[5];
        logic [7:0]         pfl[5];
        sgt_pkg::in_word_t  w;
        sfl = '{16'd100, 16'd0, 16'd65535, 16'd0, 16'd100};
        pfl = '{8'd0, 8'd255, 8'd0, 8'd0, 8'd128};
        sfl[3] = 16'($urandom_range(0, 65535));
        pfl[3] = 8'($urandom_range(0, 255));
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        write_reg(sgt_pkg::REG_STRENGTH_FLOOR, sfl[0]);
        write_reg(sgt_pkg::REG_PRIORITY_FLOOR, {8'd0, pfl[0]});
        send_word(op(sgt_pkg::MODE_READ, 16'd0, 16'd0, 8'd0, sgt_pkg::LIST_ID, 8'd0));
        send_word(op(sgt_pkg::MODE_REMOVE, 16'd5, 16'd0, 8'd0, sgt_pkg::LIST_ID, 8'd0));
        w = '1;
        w.mode = sgt_pkg::MODE_INSERT;
        w.gate_key = 16'd0;
        send_word(w);
        send_word(op(sgt_pkg::MODE_INSERT, 16'hFFFF, 16'd0, 8'd0, sgt_pkg::LIST_ID, 8'd0));
        send_word(op(sgt_pkg::MODE_INSERT, 16'd0, 16'd500, 8'd7, sgt_pkg::LIST_ID, 8'd0));
        send_word(op(sgt_pkg::MODE_INSERT, 16'h8000, 16'd101, 8'd1, sgt_pkg::LIST_ID, 8'd0));
        send_word(op(sgt_pkg::MODE_INSERT, 16'h4000, 16'd101, 8'd1, sgt_pkg::LIST_ID, 8'd0));
        send_word(op(sgt_pkg::MODE_INSERT, 16'h2000, 16'd100, 8'd255, sgt_pkg::LIST_ID,
                     8'd0));
        w = op(sgt_pkg::MODE_ACTUAL, 16'h8000, 16'd0, 8'd0, sgt_pkg::LIST_ID, 8'd0);
        w.actual_state = 2'd3;
        send_word(w);
        w.mode = sgt_pkg::MODE_WANTED;
        w.wanted_state = 2'd2;
        send_word(w);
        w.mode = sgt_pkg::MODE_DONE;
        w.done_flag = 1'b1;
        send_word(w);
        send_word(op(sgt_pkg::MODE_STRENGTH, 16'h8000, 16'd101, 8'd0, sgt_pkg::LIST_ID, 8'd0));
        send_word(op(sgt_pkg::MODE_PRIORITY, 16'h8000, 16'd0, 8'd200, sgt_pkg::LIST_ID, 8'd0));
        send_word(op(sgt_pkg::MODE_STRENGTH, 16'h1234, 16'd9, 8'd0, sgt_pkg::LIST_ID, 8'd0));
        send_word(op(sgt_pkg::MODE_READ, 16'd0, 16'd0, 8'd0, sgt_pkg::LIST_ID, 8'd3));
        send_word(op(sgt_pkg::MODE_READ, 16'd0, 16'd0, 8'd0, sgt_pkg::LIST_STRENGTH, 8'd0));
        send_word(op(sgt_pkg::MODE_READ, 16'd0, 16'd0, 8'd0, sgt_pkg::LIST_STRENGTH, 8'd1));
        send_word(op(sgt_pkg::MODE_READ, 16'd0, 16'd0, 8'd0, sgt_pkg::LIST_PRIORITY, 8'd0));
        send_word(op(sgt_pkg::MODE_READ, 16'd0, 16'd0, 8'd0, 2'd3, 8'd0));
        send_word(op(sgt_pkg::MODE_READ, 16'd0, 16'd0, 8'd0, sgt_pkg::LIST_ID, 8'd255));
        send_word(op(sgt_pkg::MODE_REMOVE, 16'hFFFF, 16'd0, 8'd0, sgt_pkg::LIST_ID, 8'd0));
        send_word(op(sgt_pkg::MODE_READ, 16'd0, 16'd0, 8'd0, sgt_pkg::LIST_PRIORITY, 8'd1));

        for (int p = 0; p < 5; p++) begin
            if (p > 0) begin
                drain();
                write_reg(sgt_pkg::REG_STRENGTH_FLOOR, sfl[p]);
                write_reg(sgt_pkg::REG_PRIORITY_FLOOR, {8'd0, pfl[p]});
            end
            if (p == 2) hold_req = 1'b1;
            for (int i = 0; i < PHASE_WORDS; i++) begin
                no_idle = (p == 1 && i < 150);
                send_word(make_word());
            end
            no_idle = 1'b0;
        end
        drain();
        repeat (200) @(negedge aclk);

        $display("Sent %0d words over five floor settings, %0d results checked.",
                 sent, sb.checked);
        $display("Covered inserts to a full table, duplicates, ties, floor edges and stalls.");
        if (sb.errors == 0 && sb.want_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
sv/sgt_pkg.sv
sv/sgt_rank_count.sv
sv/sorted_gate_table_with_rankings.sv
test/sorted_gate_table_with_rankings_tb.sv
